// File: rtl/core/telegram_sum16_deframer_assert.svh
// assertion macros for the telegram deframer checker
`ifndef TELEGRAM_SUM16_DEFRAMER_ASSERT_SVH
`define TELEGRAM_SUM16_DEFRAMER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define TSD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed: same-cycle implication");

// next-cycle implication, sampled on the rising clock, off during reset
`define TSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed: next-cycle implication");

`endif

// File: rtl/core/tsd_pkg.sv
// shared types and constants of the telegram deframer
package tsd_pkg;

  // frame layout
  localparam logic [4:0] HDR_LEN     = 5'd3;
  localparam logic [4:0] OBJ_POS     = 5'd2;
  localparam logic [7:0] DEV_ERR_OBJ = 8'hFF;

  // frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_DEV_ERR  = 2'd2;

  // one result beat
  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_payload;
    logic [3:0] payload_index;
    logic       frame_end;
    logic [1:0] frame_status;
    logic [7:0] device_error_code;
    logic [7:0] object_code;
    logic [4:0] payload_count;
  } res_t;

  // handshake between the input and output stages
  typedef struct packed {
    logic move;
  } hs_t;

endpackage

// File: rtl/core/tsd_in_stage.sv
// input register stage of the telegram deframer
module tsd_in_stage
  import tsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  input  logic       down_ready,
  output hs_t        hs,
  output logic [7:0] byte_o
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  // beat moves on when the output stage can take it
  assign hs.move  = valid_r && down_ready;
  assign in_stall = valid_r && !down_ready;
  assign accept   = in_valid && !in_stall;
  assign byte_o   = byte_r;

  // occupancy of the input register
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (hs.move) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// File: rtl/core/tsd_frame_ctl.sv
// frame tracking, running checksum and result build
module tsd_frame_ctl
  import tsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  logic [4:0]  pos_r, pos_nxt;
  logic [4:0]  flen_r, flen_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  obj_r, obj_nxt;
  logic [7:0]  fpb_r, fpb_nxt;
  logic [7:0]  chk_r, chk_nxt;

  // per-byte frame update
  always_comb begin
    logic        hdr;
    logic [4:0]  plen;
    logic [4:0]  lim;
    logic [4:0]  pofs;
    logic [15:0] sum_base;
    logic [7:0]  fpb_base;
    logic [7:0]  chk_base;
    logic        mismatch;

    hdr      = (pos_r == 5'd0);
    plen     = hdr ? ({1'b0, rx_byte[3:0]} + 5'd1) : flen_r;
    sum_base = hdr ? 16'd0 : sum_r;
    fpb_base = hdr ? 8'd0 : fpb_r;
    chk_base = hdr ? 8'd0 : chk_r;
    obj_nxt  = hdr ? 8'd0 : obj_r;
    lim      = HDR_LEN + plen;
    pofs     = pos_r - HDR_LEN;
    mismatch = 1'b0;

    if (pos_r == OBJ_POS) begin
      obj_nxt = rx_byte;
    end

    flen_nxt = plen;
    sum_nxt  = sum_base;
    fpb_nxt  = fpb_base;
    chk_nxt  = chk_base;
    pos_nxt  = pos_r + 5'd1;

    res.byte_value    = rx_byte;
    res.is_payload    = 1'b0;
    res.payload_index = 4'd0;
    res.frame_end     = 1'b0;
    res.frame_status  = ST_OK;

    if (pos_r < lim) begin
      // header, address, object or payload byte: add into the checksum
      sum_nxt = sum_base + {8'h00, rx_byte};
      if (pos_r >= HDR_LEN) begin
        res.is_payload    = 1'b1;
        res.payload_index = pofs[3:0];
        if (pofs[3:0] == 4'd0) begin
          fpb_nxt = rx_byte;
        end
      end
    end else if (pos_r == lim) begin
      // high checksum byte
      chk_nxt = rx_byte;
    end else begin
      // low checksum byte closes the frame
      mismatch      = (chk_base != sum_base[15:8]) || (rx_byte != sum_base[7:0]);
      res.frame_end = 1'b1;
      pos_nxt       = 5'd0;
      if (mismatch) begin
        res.frame_status = ST_MISMATCH;
      end else if ((obj_nxt == DEV_ERR_OBJ) && (fpb_base != 8'd0)) begin
        res.frame_status = ST_DEV_ERR;
      end
    end

    res.device_error_code = fpb_nxt;
    res.object_code       = obj_nxt;
    res.payload_count     = plen;
  end

  // frame state, advanced once per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 5'd0;
      flen_r <= 5'd0;
      sum_r  <= 16'd0;
      obj_r  <= 8'd0;
      fpb_r  <= 8'd0;
      chk_r  <= 8'd0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      flen_r <= flen_nxt;
      sum_r  <= sum_nxt;
      obj_r  <= obj_nxt;
      fpb_r  <= fpb_nxt;
      chk_r  <= chk_nxt;
    end
  end

endmodule

// File: rtl/core/tsd_out_stage.sv
// result register stage of the telegram deframer
module tsd_out_stage
  import tsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  hs_t  hs,
  input  res_t res,
  input  logic out_stall,
  output logic ready,
  output logic out_valid,
  output res_t out_res
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // free when empty or when the held beat leaves now
  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (hs.move) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (hs.move) begin
      res_r <= res;
    end
  end

endmodule

// File: rtl/core/telegram_sum16_deframer.sv
// Telegram deframer: takes a reply telegram one byte per beat and returns one result beat
// per byte, echoing the byte with its payload mark and index, the frame's object byte,
// payload length and first payload byte, and on the low checksum byte the frame status
// (ok, checksum mismatch, device error). A byte passes an input register and a result
// register, either of which out_stall can hold; one byte per cycle is sustained while out_stall
// is low, set by the once-per-beat update of the frame position and 16-bit running sum.
// Framing starts at reset and after every frame end, with no timeout or resync.
module telegram_sum16_deframer
  import tsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_value,
  output logic       out_is_payload,
  output logic [3:0] out_payload_index,
  output logic       out_frame_end,
  output logic [1:0] out_frame_status,
  output logic [7:0] out_device_error_code,
  output logic [7:0] out_object_code,
  output logic [4:0] out_payload_count
);

  hs_t        hs;
  logic       down_ready;
  logic [7:0] cur_byte;
  res_t       res;
  res_t       out_res;

  // input register
  tsd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .down_ready (down_ready),
    .hs         (hs),
    .byte_o     (cur_byte)
  );

  // frame tracking
  tsd_frame_ctl u_ctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (hs.move),
    .rx_byte (cur_byte),
    .res     (res)
  );

  // result register
  tsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .hs        (hs),
    .res       (res),
    .out_stall (out_stall),
    .ready     (down_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // result fields to ports
  assign out_byte_value        = out_res.byte_value;
  assign out_is_payload        = out_res.is_payload;
  assign out_payload_index     = out_res.payload_index;
  assign out_frame_end         = out_res.frame_end;
  assign out_frame_status      = out_res.frame_status;
  assign out_device_error_code = out_res.device_error_code;
  assign out_object_code       = out_res.object_code;
  assign out_payload_count     = out_res.payload_count;

endmodule

// File: rtl/core/tsd_checker.sv
// port-level checks of the telegram deframer, bound to the top level
`include "telegram_sum16_deframer_assert.svh"

module tsd_checker
  import tsd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic [7:0] in_rx_byte,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte_value,
  input logic       out_is_payload,
  input logic [3:0] out_payload_index,
  input logic       out_frame_end,
  input logic [1:0] out_frame_status,
  input logic [7:0] out_device_error_code,
  input logic [7:0] out_object_code,
  input logic [4:0] out_payload_count
);

  logic pl_first;
  logic pl_idx_ok;
  logic dev_err_end;
  logic dev_err_ok;

  // conditions on the result beat
  assign pl_first    = out_valid && out_is_payload && (out_payload_index == 4'd0);
  assign pl_idx_ok   = {1'b0, out_payload_index} < out_payload_count;
  assign dev_err_end = out_valid && out_frame_end && (out_frame_status == ST_DEV_ERR);
  assign dev_err_ok  = (out_object_code == DEV_ERR_OBJ) && (out_device_error_code != 8'd0);

  // a held input beat keeps its byte
  `TSD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_rx_byte))

  // a held result beat keeps its byte
  `TSD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_byte_value))

  // first payload byte is the one reported as error code
  `TSD_ASSERT_IMPLY(a_first_pl, pl_first, out_device_error_code == out_byte_value)

  // payload index stays inside the announced length
  `TSD_ASSERT_IMPLY(a_pl_idx, out_valid && out_is_payload, pl_idx_ok)

  // device error only with the error object and a nonzero code
  `TSD_ASSERT_IMPLY(a_dev_err, dev_err_end, dev_err_ok)

endmodule

bind telegram_sum16_deframer tsd_checker u_tsd_checker (.*);

// File: tb/telegram_sum16_deframer_checker.sv
// checker for the telegram deframer: predicts each result beat and compares it field by field
`timescale 1ns / 100ps
module telegram_sum16_deframer_checker
  import tsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte_value,
  input  logic        out_is_payload,
  input  logic [3:0]  out_payload_index,
  input  logic        out_frame_end,
  input  logic [1:0]  out_frame_status,
  input  logic [7:0]  out_device_error_code,
  input  logic [7:0]  out_object_code,
  input  logic [4:0]  out_payload_count,
  output int unsigned n_fail,
  output int unsigned n_pending,
  output int unsigned n_checked,
  output int unsigned n_ok_frames,
  output int unsigned n_sum_errors,
  output int unsigned n_dev_errors
);

  // position and running totals of the frame being received
  logic [4:0]  frame_pos;
  logic [4:0]  frame_len;
  logic [15:0] byte_sum;
  logic [7:0]  obj_byte;
  logic [7:0]  first_pl;
  logic [7:0]  sum_hi;

  // result beats predicted but not yet seen
  res_t pending_results[$];

  // work out the result beat for one received byte and advance the frame state
  task automatic deframe_byte(input logic [7:0] b, output res_t r);
    logic [4:0] off;
    r = '0;
    if (frame_pos == 5'd0) begin
      frame_len = {1'b0, b[3:0]} + 5'd1;
      byte_sum  = '0;
      obj_byte  = '0;
      first_pl  = '0;
      sum_hi    = '0;
    end
    if (frame_pos == OBJ_POS) begin
      obj_byte = b;
    end
    r.byte_value = b;
    if (frame_pos < HDR_LEN + frame_len) begin
      // header, address, object and payload all feed the sum
      byte_sum = byte_sum + {8'h00, b};
      if (frame_pos >= HDR_LEN) begin
        off = frame_pos - HDR_LEN;
        r.is_payload    = 1'b1;
        r.payload_index = off[3:0];
        if (off[3:0] == 4'd0) begin
          first_pl = b;
        end
      end
      frame_pos = frame_pos + 5'd1;
    end else if (frame_pos == HDR_LEN + frame_len) begin
      sum_hi    = b;
      frame_pos = frame_pos + 5'd1;
    end else begin
      // low checksum byte closes the frame; a bad sum outranks a device error
      r.frame_end = 1'b1;
      if (sum_hi != byte_sum[15:8] || b != byte_sum[7:0]) begin
        r.frame_status = ST_MISMATCH;
      end else if (obj_byte == DEV_ERR_OBJ && first_pl != 8'd0) begin
        r.frame_status = ST_DEV_ERR;
      end else begin
        r.frame_status = ST_OK;
      end
      frame_pos = '0;
    end
    r.device_error_code = first_pl;
    r.object_code       = obj_byte;
    r.payload_count     = frame_len;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  // predict on every accepted byte, compare on every accepted result beat
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      frame_pos = '0;
      frame_len = '0;
      byte_sum  = '0;
      obj_byte  = '0;
      first_pl  = '0;
      sum_hi    = '0;
      pending_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte, want);
        pending_results.push_back(want);
        if (want.frame_end) begin
          case (want.frame_status)
            ST_OK:       n_ok_frames++;
            ST_MISMATCH: n_sum_errors++;
            default:     n_dev_errors++;
          endcase
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no byte outstanding, byte_value 0x%0h", out_byte_value);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          check_field("byte_value", want.byte_value, out_byte_value);
          check_field("is_payload", want.is_payload, out_is_payload);
          check_field("payload_index", want.payload_index, out_payload_index);
          check_field("frame_end", want.frame_end, out_frame_end);
          check_field("frame_status", want.frame_status, out_frame_status);
          check_field("device_error_code", want.device_error_code, out_device_error_code);
          check_field("object_code", want.object_code, out_object_code);
          check_field("payload_count", want.payload_count, out_payload_count);
          n_checked++;
        end
      end
    end
    n_pending <= pending_results.size();
  end

endmodule

// File: tb/tb_telegram_sum16_deframer.sv
// testbench top for the telegram deframer: drives framed byte traffic and gives the verdict
`timescale 1ns / 100ps
module tb_telegram_sum16_deframer;
  import tsd_pkg::*;

  localparam int IDLE_PCT     = 37;
  localparam int N_RANDOM     = 600;
  localparam int N_DIRECTED   = 24;
  localparam int QUIET_LO     = 300;
  localparam int QUIET_HI     = 420;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  // damage applied to the checksum of a built frame
  localparam int FLT_NONE = 0;
  localparam int FLT_HIGH = 1;
  localparam int FLT_LOW  = 2;
  localparam int FLT_BOTH = 3;

  // address and payload filler: a fixed byte, or random
  localparam int FILL_RANDOM = -1;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall  = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte_value;
  logic       out_is_payload;
  logic [3:0] out_payload_index;
  logic       out_frame_end;
  logic [1:0] out_frame_status;
  logic [7:0] out_device_error_code;
  logic [7:0] out_object_code;
  logic [4:0] out_payload_count;

  int unsigned n_fail;
  int unsigned n_pending;
  int unsigned n_checked;
  int unsigned n_ok_frames;
  int unsigned n_sum_errors;
  int unsigned n_dev_errors;

  logic [7:0]  telegram_bytes[$];
  int unsigned sent_cnt;
  int unsigned next_idx;
  int unsigned stuck_cycles;

  telegram_sum16_deframer u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_rx_byte            (in_rx_byte),
    .in_stall              (in_stall),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_byte_value        (out_byte_value),
    .out_is_payload        (out_is_payload),
    .out_payload_index     (out_payload_index),
    .out_frame_end         (out_frame_end),
    .out_frame_status      (out_frame_status),
    .out_device_error_code (out_device_error_code),
    .out_object_code       (out_object_code),
    .out_payload_count     (out_payload_count)
  );

  telegram_sum16_deframer_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_byte_value        (out_byte_value),
    .out_is_payload        (out_is_payload),
    .out_payload_index     (out_payload_index),
    .out_frame_end         (out_frame_end),
    .out_frame_status      (out_frame_status),
    .out_device_error_code (out_device_error_code),
    .out_object_code       (out_object_code),
    .out_payload_count     (out_payload_count),
    .n_fail                (n_fail),
    .n_pending             (n_pending),
    .n_checked             (n_checked),
    .n_ok_frames           (n_ok_frames),
    .n_sum_errors          (n_sum_errors),
    .n_dev_errors          (n_dev_errors)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] fill_byte(input int fill);
    return (fill == FILL_RANDOM) ? 8'($urandom_range(255)) : 8'(fill);
  endfunction

  // build one telegram with a correct or damaged checksum and queue its bytes
  task automatic add_frame(input logic [3:0] hdr_hi, input int unsigned n_pl,
                           input logic [7:0] obj, input logic [7:0] first,
                           input int fill, input int fault);
    logic [7:0]  fr[$];
    logic [15:0] sum;
    logic [7:0]  flip;
    sum = '0;
    fr.push_back({hdr_hi, 4'(n_pl - 1)});
    fr.push_back(fill_byte(fill));
    fr.push_back(obj);
    for (int i = 0; i < n_pl; i++) begin
      fr.push_back((i == 0) ? first : fill_byte(fill));
    end
    foreach (fr[i]) begin
      sum = sum + {8'h00, fr[i]};
    end
    flip = 8'($urandom_range(255, 1));
    fr.push_back((fault == FLT_HIGH || fault == FLT_BOTH) ? sum[15:8] ^ flip : sum[15:8]);
    fr.push_back((fault == FLT_LOW || fault == FLT_BOTH) ? sum[7:0] ^ flip : sum[7:0]);
    foreach (fr[i]) begin
      telegram_bytes.push_back(fr[i]);
    end
  endtask

  // stimulus build, reset and verdict
  initial begin : stimulus
    int unsigned n_pl;
    int          fault;
    int          fill;
    logic [7:0]  obj;
    logic [7:0]  first;
    // all-zero shortest frame
    add_frame(4'h0, 1, 8'h00, 8'h00, 8'h00, FLT_NONE);
    // address, object and payload bytes all ones with the error object: device error
    add_frame(4'hF, 1, DEV_ERR_OBJ, 8'hFF, 8'hFF, FLT_NONE);
    // error object but zero first payload byte: still ok
    add_frame(4'hA, 1, DEV_ERR_OBJ, 8'h00, FILL_RANDOM, FLT_NONE);
    // device error hidden behind a bad low checksum byte
    add_frame(4'h5, 1, DEV_ERR_OBJ, 8'h3C, FILL_RANDOM, FLT_LOW);

    // random telegrams, mostly well formed, some with damaged checksums
    while (telegram_bytes.size() < N_DIRECTED + N_RANDOM) begin
      // open with the longest payload so the full length is always seen
      n_pl  = (telegram_bytes.size() == N_DIRECTED) ? 16 : $urandom_range(16, 1);
      obj   = ($urandom_range(3) == 0) ? DEV_ERR_OBJ : 8'($urandom_range(255));
      first = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
      case ($urandom_range(19))
        0:       fill = 0;
        1:       fill = 255;
        default: fill = FILL_RANDOM;
      endcase
      fault = ($urandom_range(9) < 7) ? FLT_NONE : int'($urandom_range(FLT_BOTH, FLT_HIGH));
      add_frame(4'($urandom_range(15)), n_pl, obj, first, fill, fault);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (sent_cnt == telegram_bytes.size());
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes, checked %0d result beats over %0d frames", telegram_bytes.size(),
             n_checked, n_ok_frames + n_sum_errors + n_dev_errors);
    $display("frame ends: %0d ok, %0d bad checksum, %0d device error", n_ok_frames,
             n_sum_errors, n_dev_errors);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // byte sender: random gaps outside the quiet window, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_idx = sent_cnt + ((in_valid && !in_stall) ? 1 : 0);
      sent_cnt <= next_idx;
      if (!in_valid || !in_stall) begin
        if (next_idx < telegram_bytes.size() &&
            ((next_idx >= QUIET_LO && next_idx < QUIET_HI) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          in_valid   <= 1'b1;
          in_rx_byte <= telegram_bytes[next_idx];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n || (sent_cnt >= QUIET_LO && sent_cnt < QUIET_HI)) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog: cycles in a row with no beat moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stuck_cycles >= STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule
